### design/sqoe_pkg.sv
// Shared types and codes for the stack/queue opcode engine.
package sqoe_pkg;

   // Opcodes carried in a request.
   localparam logic [2:0] ACT_PUSH      = 3'd0;
   localparam logic [2:0] ACT_PRINT_ALL = 3'd1;
   localparam logic [2:0] ACT_ADD       = 3'd2;
   localparam logic [2:0] ACT_PRINT_TOP = 3'd3;
   localparam logic [2:0] ACT_SWAP      = 3'd4;

   // Error codes returned in a response.
   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_BAD_ARG   = 3'd1;
   localparam logic [2:0] ERR_ADD_SHORT = 3'd2;
   localparam logic [2:0] ERR_TOP_EMPTY = 3'd3;
   localparam logic [2:0] ERR_SWAP_SHORT = 3'd4;
   localparam logic [2:0] ERR_FULL      = 3'd5;

   typedef struct packed {
      logic [2:0]         action;
      logic signed [31:0] push_value;
      logic               value_ok;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_value;
      logic [2:0]         error_code;
      logic               last;
   } rsp_type;

   // Classified operation handed from front end to back end.
   typedef enum logic [2:0] {
      OP_NONE,
      OP_PUSH,
      OP_BAD_ARG,
      OP_PRINT_ALL,
      OP_ADD,
      OP_PRINT_TOP,
      OP_SWAP
   } op_type;

   typedef struct packed {
      op_type             op;
      logic signed [31:0] value;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_TOP,
      ST_ADD,
      ST_SWAP_LO,
      ST_SWAP_HI
   } back_state_type;

endpackage

### design/sqoe_front.sv
// Front end: accepts requests, decodes opcodes into commands.
module sqoe_front
   import sqoe_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    cmd_valid,
   output cmd_type cmd_data,
   input  logic    cmd_ready
);

   logic    hold_valid_ff, hold_valid_in;
   cmd_type hold_ff, hold_in;
   logic    accept;
   op_type  op_dec;

   always_comb begin
      unique case (req_data.action)
         ACT_PUSH:      op_dec = req_data.value_ok ? OP_PUSH : OP_BAD_ARG;
         ACT_PRINT_ALL: op_dec = OP_PRINT_ALL;
         ACT_ADD:       op_dec = OP_ADD;
         ACT_PRINT_TOP: op_dec = OP_PRINT_TOP;
         ACT_SWAP:      op_dec = OP_SWAP;
         default:       op_dec = OP_NONE;
      endcase
   end

   assign req_stall = hold_valid_ff && !cmd_ready;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      if (hold_valid_ff && cmd_ready) begin
         hold_valid_in = 1'b0;
      end
      // unknown opcodes are dropped here
      if (accept) begin
         hold_valid_in = (op_dec != OP_NONE);
         hold_in.op    = op_dec;
         hold_in.value = req_data.push_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_ff <= hold_in;
   end

   assign cmd_valid = hold_valid_ff;
   assign cmd_data  = hold_ff;

endmodule

### design/sqoe_cmd_queue.sv
// Two-entry command queue between front end and back end.
module sqoe_cmd_queue
   import sqoe_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  cmd_type push_data,
   output logic    push_ready,
   output logic    pop_valid,
   output cmd_type pop_data,
   input  logic    pop_ready
);

   cmd_type    slots_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       do_push, do_pop;

   assign push_ready = (fill_ff != 2'd2);
   assign pop_valid  = (fill_ff != 2'd0);
   assign pop_data   = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### design/sqoe_back.sv
// Back end: ring store, sequencer and response register.
module sqoe_back
   import sqoe_pkg::*;
#(
   parameter int DEPTH = 64
)(
   input  logic    clock,
   input  logic    reset,
   input  logic    queue_mode,
   input  logic    cmd_valid,
   input  cmd_type cmd_data,
   output logic    cmd_pop,
   output logic    rsp_valid,
   output rsp_type rsp_data,
   input  logic    rsp_stall
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW:0]   DEPTH_W  = (AW + 1)'(DEPTH);
   localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
   localparam logic [CW-1:0] TWO_CNT  = CW'(2);

   function automatic logic [AW-1:0] ring_at(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
      logic [AW:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= DEPTH_W) begin
         sum = sum - DEPTH_W;
      end
      return sum[AW-1:0];
   endfunction

   logic signed [31:0] entries_ff [DEPTH];
   logic signed [31:0] rd_a_ff, rd_b_ff;

   back_state_type state_ff, state_in;
   logic [AW-1:0]  top_ff, top_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [AW-1:0]  idx_ff, idx_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff, rsp_in;

   logic               out_free;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic signed [31:0] wr_data;
   logic [AW-1:0]      rd_addr_a, rd_addr_b;
   logic [AW-1:0]      second;
   logic [AW-1:0]      top_dec;
   logic               idx_last;
   logic               emit;
   rsp_type            emit_data;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign second   = ring_at(top_ff, AW'(1));
   assign top_dec  = (top_ff == '0) ? LAST_IDX : top_ff - 1'b1;
   assign idx_last = ((CW'(idx_ff) + 1'b1) == count_ff);
   assign rd_addr_b = second;

   always_comb begin
      state_in  = state_ff;
      top_in    = top_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      cmd_pop   = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = top_ff;
      wr_data   = rd_a_ff;
      rd_addr_a = top_ff;
      emit      = 1'b0;
      emit_data = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_pop = 1'b1;
               emit_data.last = 1'b1;
               unique case (cmd_data.op)
                  OP_NONE: begin
                  end
                  OP_BAD_ARG: begin
                     emit = 1'b1;
                     emit_data.error_code = ERR_BAD_ARG;
                  end
                  OP_PUSH: begin
                     if (count_ff == FULL_CNT) begin
                        emit = 1'b1;
                        emit_data.error_code = ERR_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        wr_data = cmd_data.value;
                        if (queue_mode) begin
                           wr_addr = ring_at(top_ff, count_ff[AW-1:0]);
                        end else begin
                           wr_addr = top_dec;
                           top_in  = top_dec;
                        end
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_PRINT_ALL: begin
                     if (count_ff != '0) begin
                        idx_in   = '0;
                        state_in = ST_WALK;
                     end
                  end
                  OP_ADD: begin
                     if (count_ff < TWO_CNT) begin
                        emit = 1'b1;
                        emit_data.error_code = ERR_ADD_SHORT;
                     end else begin
                        state_in = ST_ADD;
                     end
                  end
                  OP_PRINT_TOP: begin
                     if (count_ff == '0) begin
                        emit = 1'b1;
                        emit_data.error_code = ERR_TOP_EMPTY;
                     end else begin
                        state_in = ST_TOP;
                     end
                  end
                  OP_SWAP: begin
                     if (count_ff < TWO_CNT) begin
                        emit = 1'b1;
                        emit_data.error_code = ERR_SWAP_SHORT;
                     end else begin
                        state_in = ST_SWAP_LO;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WALK: begin
            // rd_a_ff holds the entry at idx_ff; prefetch the next one on emit
            rd_addr_a = ring_at(top_ff, idx_ff);
            if (out_free) begin
               emit                 = 1'b1;
               emit_data.out_value  = rd_a_ff;
               emit_data.error_code = ERR_NONE;
               emit_data.last       = idx_last;
               if (idx_last) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in    = idx_ff + 1'b1;
                  rd_addr_a = ring_at(top_ff, idx_ff + 1'b1);
               end
            end
         end
         ST_TOP: begin
            if (out_free) begin
               emit                 = 1'b1;
               emit_data.out_value  = rd_a_ff;
               emit_data.error_code = ERR_NONE;
               emit_data.last       = 1'b1;
               state_in             = ST_IDLE;
            end
         end
         ST_ADD: begin
            wr_en    = 1'b1;
            wr_addr  = second;
            wr_data  = rd_a_ff + rd_b_ff;
            top_in   = second;
            count_in = count_ff - 1'b1;
            state_in = ST_IDLE;
         end
         ST_SWAP_LO: begin
            wr_en    = 1'b1;
            wr_addr  = top_ff;
            wr_data  = rd_b_ff;
            state_in = ST_SWAP_HI;
         end
         ST_SWAP_HI: begin
            // rd_a_ff still has the old top: read-before-write
            wr_en    = 1'b1;
            wr_addr  = second;
            wr_data  = rd_a_ff;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = emit_data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         top_ff       <= '0;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         top_ff       <= top_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= entries_ff[rd_addr_a];
      rd_b_ff <= entries_ff[rd_addr_b];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### design/stack_queue_opcode_engine.sv
// Top level of the stack/queue opcode engine.
//
//   channel   ports                          dir  request
//   req       req_valid/req_stall/req_data   in   one opcode with push argument
//   rsp       rsp_valid/rsp_stall/rsp_data   out  printed entry or error code
//   csr       csr_valid/csr_ready/csr_data   in   queue_mode bit
//
// Push and error results are handled directly from idle. Add, swap, print
// top do a registered store read, then write-back or emit (swap uses the
// single write port twice). Print all emits N entries for N entries, one
// per cycle while rsp is not stalled. Front register plus a 2-deep command
// queue absorb requests while the back end works or rsp is stalled. Synchronous
// reset empties the store (no clearing pass; entries are only read once written).
module stack_queue_opcode_engine
   import sqoe_pkg::*;
#(
   parameter int DEPTH = 64
)(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_data
);

   logic    queue_mode_ff, queue_mode_in;

   logic    front_valid, front_ready;
   cmd_type front_cmd;
   logic    q_valid, q_pop;
   cmd_type q_cmd;

   // the user must write config only while idle; the block does not enforce it, so always ready
   assign csr_ready = 1'b1;

   always_comb begin
      queue_mode_in = queue_mode_ff;
      if (csr_valid && csr_ready) begin
         queue_mode_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         queue_mode_ff <= 1'b0;
      end else begin
         queue_mode_ff <= queue_mode_in;
      end
   end

   // decode stage
   sqoe_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cmd_valid (front_valid),
      .cmd_data  (front_cmd),
      .cmd_ready (front_ready)
   );

   // decouples decode from execution
   sqoe_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_data  (front_cmd),
      .push_ready (front_ready),
      .pop_valid  (q_valid),
      .pop_data   (q_cmd),
      .pop_ready  (q_pop)
   );

   // ring store and sequencer
   sqoe_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .queue_mode (queue_mode_ff),
      .cmd_valid  (q_valid),
      .cmd_data   (q_cmd),
      .cmd_pop    (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .rsp_stall  (rsp_stall)
   );

endmodule
